@@ rtl/core/mrcs_pkg.sv @@
// Shared types and constants for the matrix row and column swapper.
package mrcs_pkg;

  // Operation code carried by every input beat.
  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_SWAP_ROWS = 2'd1,
    OP_SWAP_COLS = 2'd2,
    OP_READ      = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_ROW_COUNT    = 1'b0,
    CFG_COLUMN_COUNT = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW = 5;

  // Payload of one command beat.
  typedef struct packed {
    op_e                operation;
    logic        [3:0]  row;
    logic        [3:0]  column;
    logic signed [31:0] value;
    logic        [4:0]  first_index;
    logic        [4:0]  second_index;
  } in_beat_t;

  // Payload of one result beat.
  typedef struct packed {
    logic signed [31:0] element_value;
    logic        [3:0]  out_row;
    logic        [3:0]  out_column;
  } out_beat_t;

endpackage

@@ rtl/core/mrcs_if.sv @@
// Valid/ready channel interfaces for command and result beats.
interface mrcs_in_if;
  logic               valid;
  logic               ready;
  mrcs_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrcs_out_if;
  logic                valid;
  logic                ready;
  mrcs_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/matrix_row_column_swapper.sv @@
// Matrix row and column swapper: element store with row and column remap tables.
//
//   Channel   Direction  Handshake         Payload
//   in_ch     sink       valid / ready     operation, row, column, value,
//                                          first_index, second_index
//   out_ch    source     valid / ready     element_value, out_row, out_column
//   cfg       input      cfg_we_i          cfg_index_i, cfg_data_i
//
// One command beat can be taken every cycle while no read waits on a stalled result.
// A beat lands in a command register; when it leaves that register it updates a remap
// table, writes the element store, or reads the store into the result register, from
// which a read result is offered on out_ch.
// Reset restores identity remap tables and counts of 16; the store is not reset.
// A stalled result holds back a read in the command register, and every beat behind it.

module matrix_row_column_swapper #(
  parameter int unsigned MAX_ROWS      = 16,
  parameter int unsigned MAX_COLUMNS   = 16,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  mrcs_pkg::cfg_idx_e             cfg_index_i,
  input  logic [mrcs_pkg::CfgDataW-1:0]  cfg_data_i,
  mrcs_in_if.sink                        in_ch,
  mrcs_out_if.source                     out_ch
);

  localparam int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned MemDepth = 2 ** (RowW + ColW);

  // Identity contents of the remap tables after reset.
  function automatic logic [MAX_ROWS-1:0][RowW-1:0] row_identity();
    logic [MAX_ROWS-1:0][RowW-1:0] m;
    for (int i = 0; i < MAX_ROWS; i++) begin
      m[i] = RowW'(i);
    end
    return m;
  endfunction

  function automatic logic [MAX_COLUMNS-1:0][ColW-1:0] col_identity();
    logic [MAX_COLUMNS-1:0][ColW-1:0] m;
    for (int i = 0; i < MAX_COLUMNS; i++) begin
      m[i] = ColW'(i);
    end
    return m;
  endfunction

  localparam logic [MAX_ROWS-1:0][RowW-1:0]    RowIdentity = row_identity();
  localparam logic [MAX_COLUMNS-1:0][ColW-1:0] ColIdentity = col_identity();

  // Configuration registers.
  logic [mrcs_pkg::CfgDataW-1:0] row_count_q, column_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= 5'd16;
      column_count_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mrcs_pkg::CFG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        mrcs_pkg::CFG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Counts above the table depth behave as the depth.
  logic [mrcs_pkg::CfgDataW-1:0] rows_eff, cols_eff;
  assign rows_eff = (32'(row_count_q) > MAX_ROWS) ? 5'(MAX_ROWS) : row_count_q;
  assign cols_eff = (32'(column_count_q) > MAX_COLUMNS) ? 5'(MAX_COLUMNS)
                                                        : column_count_q;

  // Command register.
  logic               cmd_valid_q;
  mrcs_pkg::in_beat_t cmd_q;
  logic               out_valid_q;
  logic               out_free, cmd_fire, in_fire;

  assign out_free     = !out_valid_q || out_ch.ready;
  assign cmd_fire     = cmd_valid_q && (cmd_q.operation != mrcs_pkg::OP_READ || out_free);
  assign in_ch.ready  = !cmd_valid_q || cmd_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (in_fire) begin
      cmd_valid_q <= 1'b1;
    end else if (cmd_fire) begin
      cmd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= in_ch.data;
    end
  end

  // Decode of the held command.
  logic is_load, is_read, is_swap_rows, is_swap_cols, in_bounds;
  logic row_swap_ok, col_swap_ok;

  assign is_load      = cmd_fire && cmd_q.operation == mrcs_pkg::OP_LOAD;
  assign is_read      = cmd_fire && cmd_q.operation == mrcs_pkg::OP_READ;
  assign is_swap_rows = cmd_fire && cmd_q.operation == mrcs_pkg::OP_SWAP_ROWS;
  assign is_swap_cols = cmd_fire && cmd_q.operation == mrcs_pkg::OP_SWAP_COLS;
  assign in_bounds    = (5'(cmd_q.row) < rows_eff) && (5'(cmd_q.column) < cols_eff);

  // A swap is dropped when either one-based index is zero or past the count.
  assign row_swap_ok = cmd_q.first_index != 5'd0 && cmd_q.second_index != 5'd0 &&
                       cmd_q.first_index <= rows_eff && cmd_q.second_index <= rows_eff;
  assign col_swap_ok = cmd_q.first_index != 5'd0 && cmd_q.second_index != 5'd0 &&
                       cmd_q.first_index <= cols_eff && cmd_q.second_index <= cols_eff;

  // Remap tables: logical row or column to physical storage position.
  logic [MAX_ROWS-1:0][RowW-1:0]    row_map_q, row_map_d;
  logic [MAX_COLUMNS-1:0][ColW-1:0] col_map_q, col_map_d;
  logic [RowW-1:0] row_a, row_b;
  logic [ColW-1:0] col_a, col_b;

  assign row_a = RowW'(cmd_q.first_index - 5'd1);
  assign row_b = RowW'(cmd_q.second_index - 5'd1);
  assign col_a = ColW'(cmd_q.first_index - 5'd1);
  assign col_b = ColW'(cmd_q.second_index - 5'd1);

  // Both entries read the old table, so equal indices leave it unchanged.
  always_comb begin
    row_map_d = row_map_q;
    if (is_swap_rows && row_swap_ok) begin
      row_map_d[row_a] = row_map_q[row_b];
      row_map_d[row_b] = row_map_q[row_a];
    end
  end

  always_comb begin
    col_map_d = col_map_q;
    if (is_swap_cols && col_swap_ok) begin
      col_map_d[col_a] = col_map_q[col_b];
      col_map_d[col_b] = col_map_q[col_a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_map_q <= RowIdentity;
    end else begin
      row_map_q <= row_map_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_map_q <= ColIdentity;
    end else begin
      col_map_q <= col_map_d;
    end
  end

  // Physical address of the element at the held logical position.
  logic [RowW-1:0]      phys_row;
  logic [ColW-1:0]      phys_col;
  logic [RowW+ColW-1:0] mem_addr;

  assign phys_row = row_map_q[RowW'(cmd_q.row)];
  assign phys_col = col_map_q[ColW'(cmd_q.column)];
  assign mem_addr = {phys_row, phys_col};

  // Element store, one write and one registered read per cycle. The read
  // register doubles as the element field of the result register.
  logic signed [ELEMENT_WIDTH-1:0] elem_mem [MemDepth];
  logic signed [ELEMENT_WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (is_load && in_bounds) begin
      elem_mem[mem_addr] <= ELEMENT_WIDTH'(cmd_q.value);
    end
    if (is_read) begin
      rd_data_q <= elem_mem[mem_addr];
    end
  end

  // Result register.
  logic       in_bounds_q;
  logic [3:0] out_row_q, out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_read) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      in_bounds_q <= in_bounds;
      out_row_q   <= cmd_q.row;
      out_col_q   <= cmd_q.column;
    end
  end

  // A read outside the used area returns zero with the position echoed.
  assign out_ch.valid              = out_valid_q;
  assign out_ch.data.element_value = in_bounds_q ? 32'(rd_data_q) : 32'sd0;
  assign out_ch.data.out_row       = out_row_q;
  assign out_ch.data.out_column    = out_col_q;

  // A read that leaves the command register always shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> out_valid_q)
    else $error("read command did not produce a result");

  // A read never overwrites a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch.ready) |-> !is_read)
    else $error("pending result overwritten by a read");

  // A rejected row swap leaves the row remap table untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (is_swap_rows && !row_swap_ok) |=> $stable(row_map_q))
    else $error("row remap table changed on an ignored swap");

  // An empty command register never blocks the input channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_q |-> in_ch.ready)
    else $error("input stalled with an empty command register");

endmodule

@@ sim/tb_matrix_row_column_swapper.sv @@
// Self-checking testbench for the matrix row and column swapper.
`timescale 1ns / 100ps

module tb_matrix_row_column_swapper;

  // The block keeps at most 16 rows and 16 columns; larger counts saturate.
  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxCols = 16;

  // Loads and swaps give no result, so a settling wait lets them retire
  // before the counts are rewritten.
  localparam int SettleCycles = 6;

  // Run-time limit, set with ample room above the slowest legal run.
  localparam int unsigned CycleLimit = 400000;

  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int HoldOffCycles = 400;

  // Two copies of the matrix model. The planning copy runs ahead while the
  // stimulus is built, so that no read ever lands on a cell that was never
  // loaded. The live copy follows the beats that the block really accepts
  // and produces the expected results.
  localparam int Plan = 0;
  localparam int Live = 1;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  mrcs_pkg::cfg_idx_e cfg_index_i;
  logic [mrcs_pkg::CfgDataW-1:0] cfg_data_i;

  mrcs_in_if  cmd_ch ();
  mrcs_out_if res_ch ();

  matrix_row_column_swapper uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_ch       (cmd_ch),
    .out_ch      (res_ch)
  );

  // Matrix model state, one slice per copy.
  logic signed [31:0] cell_m    [2][MaxRows][MaxCols];
  bit                 loaded_m  [2][MaxRows][MaxCols];
  logic [3:0]         rowmap_m  [2][MaxRows];
  logic [3:0]         colmap_m  [2][MaxCols];
  logic [4:0]         rowcnt_m  [2];
  logic [4:0]         colcnt_m  [2];

  mrcs_pkg::in_beat_t  cmd_q[$];        // command beats waiting to be offered
  mrcs_pkg::out_beat_t expected_q[$];   // read results predicted but not yet seen

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned results_seen;
  int unsigned op_seen [4];
  int unsigned settings_run;

  // Sink-side hold-off request and its bookkeeping.
  bit hold_off_go;
  bit hold_off_done;
  int hold_left;
  int stall_left;
  int sink_calm_left;

  // Source-side gap bookkeeping.
  int gap_left;
  int src_calm_left;

  // ---------------------------------------------------------------------
  // Matrix model
  // ---------------------------------------------------------------------

  // A count above the table size acts as the table size; zero means empty.
  function automatic int unsigned used_count(logic [4:0] n, int unsigned limit);
    return (32'(n) > limit) ? limit : 32'(n);
  endfunction

  // A one-based swap index must be nonzero and within the rows or columns in use.
  function automatic bit index_ok(logic [4:0] idx, int unsigned count);
    return (idx != 5'd0) && (32'(idx) <= count);
  endfunction

  function automatic void matrix_reset(int c);
    for (int r = 0; r < MaxRows; r++) begin
      rowmap_m[c][r] = r[3:0];
      for (int k = 0; k < MaxCols; k++) begin
        cell_m[c][r][k]   = '0;
        loaded_m[c][r][k] = 1'b0;
      end
    end
    for (int k = 0; k < MaxCols; k++) colmap_m[c][k] = k[3:0];
    rowcnt_m[c] = 5'd16;
    colcnt_m[c] = 5'd16;
  endfunction

  function automatic void matrix_config(int c, mrcs_pkg::cfg_idx_e idx, logic [4:0] d);
    if (idx == mrcs_pkg::CFG_ROW_COUNT) rowcnt_m[c] = d;
    else colcnt_m[c] = d;
  endfunction

  // Applies one command to a model copy. Returns 1 when the command is a
  // read, in which case res holds the result beat the block must produce.
  function automatic bit matrix_step(int c, mrcs_pkg::in_beat_t cmd,
                                     output mrcs_pkg::out_beat_t res);
    int unsigned rows_used;
    int unsigned cols_used;
    bit          in_area;
    logic [3:0]  pr;
    logic [3:0]  pc;
    logic [3:0]  t;
    logic [3:0]  ia;
    logic [3:0]  ib;
    rows_used = used_count(rowcnt_m[c], MaxRows);
    cols_used = used_count(colcnt_m[c], MaxCols);
    in_area   = (32'(cmd.row) < rows_used) && (32'(cmd.column) < cols_used);
    pr        = rowmap_m[c][cmd.row];
    pc        = colmap_m[c][cmd.column];
    ia        = 4'(cmd.first_index - 5'd1);
    ib        = 4'(cmd.second_index - 5'd1);
    res               = '0;
    res.out_row       = cmd.row;
    res.out_column    = cmd.column;
    case (cmd.operation)
      mrcs_pkg::OP_SWAP_ROWS: begin
        if (index_ok(cmd.first_index, rows_used) && index_ok(cmd.second_index, rows_used)) begin
          t = rowmap_m[c][ia];
          rowmap_m[c][ia] = rowmap_m[c][ib];
          rowmap_m[c][ib] = t;
        end
      end
      mrcs_pkg::OP_SWAP_COLS: begin
        if (index_ok(cmd.first_index, cols_used) && index_ok(cmd.second_index, cols_used)) begin
          t = colmap_m[c][ia];
          colmap_m[c][ia] = colmap_m[c][ib];
          colmap_m[c][ib] = t;
        end
      end
      mrcs_pkg::OP_LOAD: begin
        // Loads outside the rows and columns in use are dropped.
        if (in_area) begin
          cell_m[c][pr][pc]   = cmd.value;
          loaded_m[c][pr][pc] = 1'b1;
        end
      end
      default: begin
        // A read outside the area still answers, with a zero element.
        if (in_area) res.element_value = cell_m[c][pr][pc];
      end
    endcase
    return cmd.operation == mrcs_pkg::OP_READ;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Idle lengths: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 92) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Queues one command beat. A read that would hit a cell never loaded is
  // turned into a load of that position, which keeps the store defined.
  task automatic queue_command(mrcs_pkg::in_beat_t cmd);
    mrcs_pkg::out_beat_t dummy;
    int unsigned         rows_used;
    int unsigned         cols_used;
    rows_used = used_count(rowcnt_m[Plan], MaxRows);
    cols_used = used_count(colcnt_m[Plan], MaxCols);
    if (cmd.operation == mrcs_pkg::OP_READ && 32'(cmd.row) < rows_used &&
        32'(cmd.column) < cols_used &&
        !loaded_m[Plan][rowmap_m[Plan][cmd.row]][colmap_m[Plan][cmd.column]])
      cmd.operation = mrcs_pkg::OP_LOAD;
    void'(matrix_step(Plan, cmd, dummy));
    cmd_q.push_back(cmd);
  endtask

  task automatic queue_fixed(mrcs_pkg::op_e op, int r, int k, logic [31:0] v, int a, int b);
    mrcs_pkg::in_beat_t cmd;
    cmd.operation    = op;
    cmd.row          = r[3:0];
    cmd.column       = k[3:0];
    cmd.value        = v;
    cmd.first_index  = a[4:0];
    cmd.second_index = b[4:0];
    queue_command(cmd);
  endtask

  // Mostly well-formed traffic aimed inside the area in use, with a small
  // share of raw noise: arbitrary positions and swap indices up to 31.
  task automatic queue_random_command();
    mrcs_pkg::in_beat_t cmd;
    int                 p;
    int unsigned        rows_used;
    int unsigned        cols_used;
    rows_used        = used_count(rowcnt_m[Plan], MaxRows);
    cols_used        = used_count(colcnt_m[Plan], MaxCols);
    cmd.operation    = mrcs_pkg::op_e'($urandom_range(0, 3));
    cmd.row          = 4'($urandom_range(0, 15));
    cmd.column       = 4'($urandom_range(0, 15));
    cmd.value        = $urandom;
    cmd.first_index  = 5'($urandom_range(0, 31));
    cmd.second_index = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 19) == 0) begin
      cmd.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    p = $urandom_range(0, 99);
    if (p >= 6) begin
      if (rows_used > 0) cmd.row = 4'($urandom_range(0, rows_used - 1));
      if (cols_used > 0) cmd.column = 4'($urandom_range(0, cols_used - 1));
      if (p < 40) begin
        cmd.operation = mrcs_pkg::OP_LOAD;
      end else if (p < 75) begin
        cmd.operation = mrcs_pkg::OP_READ;
      end else if (p < 88) begin
        cmd.operation = mrcs_pkg::OP_SWAP_ROWS;
        if (rows_used > 0) begin
          cmd.first_index  = 5'($urandom_range(1, rows_used));
          cmd.second_index = 5'($urandom_range(1, rows_used));
        end
      end else begin
        cmd.operation = mrcs_pkg::OP_SWAP_COLS;
        if (cols_used > 0) begin
          cmd.first_index  = 5'($urandom_range(1, cols_used));
          cmd.second_index = 5'($urandom_range(1, cols_used));
        end
      end
    end
    queue_command(cmd);
  endtask

  // Counts may only change while the block is idle, so callers drain first.
  task automatic write_count(mrcs_pkg::cfg_idx_e idx, logic [4:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    matrix_config(Plan, idx, d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Holds the sender back until every beat is taken and every result is in.
  task automatic wait_idle();
    while (cmd_q.size() != 0 || cmd_ch.valid || expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Clock and run-time limit
  // ---------------------------------------------------------------------

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Driver: offers queued command beats, with random gaps between them.
  // Valid stays high until the beat is taken, so a stall never drops data.
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data  <= '0;
      gap_left      = 0;
      src_calm_left = 0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (gap_left > 0) begin
        cmd_ch.valid <= 1'b0;
        gap_left      = gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= cmd_q.pop_front();
        // Calm stretches send back to back; otherwise a random gap follows.
        if (src_calm_left > 0) begin
          src_calm_left = src_calm_left - 1;
        end else if ($urandom_range(0, 99) == 0) begin
          src_calm_left = $urandom_range(30, 100);
        end else begin
          gap_left = pick_gap();
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result sink: random stalls, calm stretches, and one long hold-off on
  // request so that the result register stays full and the input backs up.
  // ---------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready  <= 1'b0;
      hold_left      = 0;
      stall_left     = 0;
      sink_calm_left = 0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left     = hold_left - 1;
    end else if (hold_off_go && !hold_off_done) begin
      res_ch.ready <= 1'b0;
      hold_left     = HoldOffCycles;
      hold_off_done = 1'b1;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left    = stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (sink_calm_left > 0) begin
        sink_calm_left = sink_calm_left - 1;
      end else if ($urandom_range(0, 99) == 0) begin
        sink_calm_left = $urandom_range(50, 150);
      end else begin
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: tracks count writes and accepted command beats in the live
  // model, then checks every accepted result beat against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin
    mrcs_pkg::out_beat_t predicted;
    mrcs_pkg::out_beat_t got;
    if (rst_ni) begin
      if (cfg_we_i) matrix_config(Live, cfg_index_i, cfg_data_i);
      if (cmd_ch.valid && cmd_ch.ready) begin
        op_seen[cmd_ch.data.operation] = op_seen[cmd_ch.data.operation] + 1;
        if (matrix_step(Live, cmd_ch.data, predicted)) expected_q.push_back(predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        got          = res_ch.data;
        results_seen = results_seen + 1;
        if (expected_q.size() == 0) begin
          err_cnt = err_cnt + 1;
          $display("%0t: unexpected result beat: value %0d at (%0d,%0d)",
                   $time, got.element_value, got.out_row, got.out_column);
        end else begin
          predicted = expected_q.pop_front();
          if (got.element_value !== predicted.element_value) begin
            err_cnt = err_cnt + 1;
            $display("%0t: element_value at (%0d,%0d): expected %0d, actual %0d", $time,
                     predicted.out_row, predicted.out_column,
                     predicted.element_value, got.element_value);
          end
          if (got.out_row !== predicted.out_row) begin
            err_cnt = err_cnt + 1;
            $display("%0t: out_row: expected %0d, actual %0d",
                     $time, predicted.out_row, got.out_row);
          end
          if (got.out_column !== predicted.out_column) begin
            err_cnt = err_cnt + 1;
            $display("%0t: out_column: expected %0d, actual %0d",
                     $time, predicted.out_column, got.out_column);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: reset, a directed opening at the reset counts, then random
  // traffic under a series of row and column counts. Counts change only
  // after the block has drained.
  // ---------------------------------------------------------------------

  initial begin
    // Count settings per phase: small, lopsided, zero, saturated, full.
    int row_set  [7];
    int col_set  [7];
    int item_set [7];

    row_set  = '{1, 3, 16, 0, 31, 5, 16};
    col_set  = '{1, 16, 2, 31, 0, 7, 16};
    item_set = '{70, 90, 80, 30, 30, 90, 90};

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = mrcs_pkg::CFG_ROW_COUNT;
    cfg_data_i   = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    res_ch.ready = 1'b0;
    hold_off_go   = 1'b0;
    hold_off_done = 1'b0;
    cycle_cnt     = 0;
    err_cnt       = 0;
    results_seen  = 0;
    settings_run  = 1;
    for (int i = 0; i < 4; i++) op_seen[i] = 0;
    matrix_reset(Plan);
    matrix_reset(Live);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed opening on the full 16 x 16 matrix left by reset: corner
    // loads with the extreme values, whole-row and whole-column swaps of
    // the outermost lines, ignored swaps (index zero, past the count, the
    // top of the field) and a swap of a line with itself.
    queue_fixed(mrcs_pkg::OP_LOAD, 0, 0, 32'h7fff_ffff, 0, 0);
    queue_fixed(mrcs_pkg::OP_LOAD, 15, 15, 32'h8000_0000, 0, 0);
    queue_fixed(mrcs_pkg::OP_LOAD, 0, 15, 32'hffff_ffff, 0, 0);
    queue_fixed(mrcs_pkg::OP_LOAD, 15, 0, 32'h0000_0000, 0, 0);
    queue_fixed(mrcs_pkg::OP_LOAD, 7, 8, 32'h5a5a_a5a5, 31, 31);
    queue_fixed(mrcs_pkg::OP_READ, 0, 0, 32'hffff_ffff, 0, 0);
    queue_fixed(mrcs_pkg::OP_READ, 15, 15, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_SWAP_ROWS, 0, 0, 32'h0, 1, 16);
    queue_fixed(mrcs_pkg::OP_READ, 0, 0, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_READ, 15, 0, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_SWAP_COLS, 0, 0, 32'h0, 16, 1);
    queue_fixed(mrcs_pkg::OP_READ, 0, 0, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_READ, 15, 15, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_SWAP_ROWS, 0, 0, 32'h0, 0, 3);
    queue_fixed(mrcs_pkg::OP_SWAP_ROWS, 0, 0, 32'h0, 17, 1);
    queue_fixed(mrcs_pkg::OP_SWAP_COLS, 0, 0, 32'h0, 1, 31);
    queue_fixed(mrcs_pkg::OP_SWAP_COLS, 0, 0, 32'h0, 9, 9);
    queue_fixed(mrcs_pkg::OP_SWAP_ROWS, 0, 0, 32'h0, 8, 8);
    queue_fixed(mrcs_pkg::OP_READ, 0, 15, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_READ, 7, 8, 32'h0, 0, 0);
    queue_fixed(mrcs_pkg::OP_SWAP_ROWS, 0, 0, 32'h0, 8, 1);
    queue_fixed(mrcs_pkg::OP_READ, 0, 8, 32'h0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      write_count(mrcs_pkg::CFG_ROW_COUNT, row_set[ph][4:0]);
      write_count(mrcs_pkg::CFG_COLUMN_COUNT, col_set[ph][4:0]);
      settings_run = settings_run + 1;
      @(negedge clk_i);
      // Positions past a one-by-one matrix: the load is dropped and the
      // read answers zero with the position echoed.
      if (ph == 0) begin
        queue_fixed(mrcs_pkg::OP_LOAD, 3, 0, 32'h1234_5678, 0, 0);
        queue_fixed(mrcs_pkg::OP_READ, 15, 15, 32'h0, 0, 0);
        queue_fixed(mrcs_pkg::OP_READ, 0, 0, 32'h0, 0, 0);
      end
      // In the second phase the sink holds off for a long stretch while
      // commands keep coming, which fills the block and stalls its input.
      if (ph == 1) hold_off_go = 1'b1;
      for (int n = 0; n < item_set[ph]; n++) queue_random_command();
      wait_idle();
    end

    $display("Ran %0d loads, %0d row swaps, %0d column swaps, %0d reads under %0d settings.",
             op_seen[mrcs_pkg::OP_LOAD], op_seen[mrcs_pkg::OP_SWAP_ROWS],
             op_seen[mrcs_pkg::OP_SWAP_COLS], op_seen[mrcs_pkg::OP_READ], settings_run);
    $display("Checked %0d result beats, long sink hold-off %0s, %0d mismatches.",
             results_seen, hold_off_done ? "done" : "missed", err_cnt);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
